// ===== sv/consensus_outlier_filter_vec3_assert.svh =====
// ----------------------------------------------------------------------------
// Consensus outlier filter assertion macros
// Concurrent assertion forms shared by the filter RTL.
// ----------------------------------------------------------------------------
`ifndef CONSENSUS_OUTLIER_FILTER_VEC3_ASSERT_SVH
`define CONSENSUS_OUTLIER_FILTER_VEC3_ASSERT_SVH

`ifndef SYNTH
`define COF_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);
`define COF_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);
`else
`define COF_ASSERT_NOW(lbl, ante, cons, msg)
`define COF_ASSERT_NEXT(lbl, ante, cons, msg)
`endif

`endif

// ===== sv/cof_pkg.sv =====
// ----------------------------------------------------------------------------
// Consensus outlier filter package
// Word types, sequencer states, constants and shared helper functions.
// ----------------------------------------------------------------------------
package cof_pkg;

    localparam int DEPTH_DEF    = 16;
    localparam int CORDIC_STEPS = 14;
    localparam int XW           = 26;
    localparam int ZW           = 18;
    localparam int SW           = 24;
    localparam int BW           = 17;
    localparam int CFG_IDX_W    = 2;

    localparam logic [3:0]           MISS_LIMIT  = 4'd8;
    localparam logic [15:0]          BOUND_RESET = 16'd26;
    localparam logic [BW-1:0]        BOUND_MAX   = 17'h1FFFF;
    localparam logic signed [XW-1:0] CORDIC_GAIN = 26'sd9949;
    localparam logic signed [ZW-1:0] QTR_TURN    = 18'sd16384;
    localparam logic signed [ZW-1:0] HALF_TURN   = 18'sd32768;

    localparam logic [CFG_IDX_W-1:0] CFG_BOUND = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_MODE  = 2'd1;

    localparam logic FUNC_ADD  = 1'b0;
    localparam logic FUNC_TICK = 1'b1;

    typedef struct packed {
        logic               func;
        logic signed [15:0] sample_x;
        logic signed [15:0] sample_y;
        logic signed [15:0] sample_z;
    } t_in_word;

    typedef struct packed {
        logic signed [15:0] estimate_x;
        logic signed [15:0] estimate_y;
        logic signed [15:0] estimate_z;
        logic               window_full;
        logic [6:0]         sample_count;
    } t_out_word;

    typedef enum logic [4:0] {
        S_IDLE, S_DET, S_ONE, S_LDI, S_LDI2, S_RDJ, S_CMP, S_ENDI, S_ENDP,
        S_GLDI, S_GLDI2, S_GRDJ, S_GACC, S_RINIT, S_ROT, S_AINIT, S_ATAN,
        S_DINIT, S_DIV, S_DONE
    } t_state;

    function automatic logic signed [ZW-1:0] atan_entry(input logic [3:0] i);
        logic signed [ZW-1:0] v;
        case (i)
            4'd0:    v = 18'sd8192;
            4'd1:    v = 18'sd4836;
            4'd2:    v = 18'sd2555;
            4'd3:    v = 18'sd1297;
            4'd4:    v = 18'sd651;
            4'd5:    v = 18'sd326;
            4'd6:    v = 18'sd163;
            4'd7:    v = 18'sd81;
            4'd8:    v = 18'sd41;
            4'd9:    v = 18'sd20;
            4'd10:   v = 18'sd10;
            4'd11:   v = 18'sd5;
            4'd12:   v = 18'sd3;
            4'd13:   v = 18'sd1;
            default: v = 18'sd0;
        endcase
        return v;
    endfunction

    function automatic logic signed [15:0] axis_of(input logic [47:0] w, input logic [1:0] k);
        logic signed [15:0] v;
        case (k)
            2'd0:    v = w[47:32];
            2'd1:    v = w[31:16];
            default: v = w[15:0];
        endcase
        return v;
    endfunction

    function automatic logic [BW-1:0] axis_err(input logic [15:0] a, input logic [15:0] b,
                                               input logic mode);
        logic signed [16:0] d;
        logic [BW-1:0]      lin;
        logic [BW-1:0]      ang;
        d   = {a[15], a} - {b[15], b};
        lin = d[16] ? BW'(-d) : BW'(d);
        ang = d[15] ? (17'd65536 - {1'b0, d[15:0]}) : {1'b0, d[15:0]};
        return mode ? ang : lin;
    endfunction

    function automatic logic agree(input logic [47:0] a, input logic [47:0] b,
                                   input logic [BW-1:0] bound, input logic mode);
        return (axis_err(a[47:32], b[47:32], mode) < bound) &&
               (axis_err(a[31:16], b[31:16], mode) < bound) &&
               (axis_err(a[15:0], b[15:0], mode) < bound);
    endfunction

endpackage

// ===== sv/consensus_outlier_filter_vec3.sv =====
// Per word, each bound pass compares every pair of held samples, for up to 18 passes;
// the group sweep then gathers the agreeing samples, rotating each kept sample's axes
// through the CORDIC in angle mode, and each axis ends in an arctangent or a division.
// A new word is accepted only in the idle state; the shared compare, CORDIC and divider steps run in turn.
// Reset is synchronous, active low: empty window, bound 26, linear mode.
// ----------------------------------------------------------------------------
// Consensus outlier filter, 3-axis
// Ring window of samples with a bound-doubling consensus search and a mean or
// circular mean over the best agreeing group, run by a small sequencer.
// ----------------------------------------------------------------------------
`include "consensus_outlier_filter_vec3_assert.svh"

module consensus_outlier_filter_vec3 #(
    parameter int DEPTH = cof_pkg::DEPTH_DEF
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_valid,
    output logic                           o_stall,
    input  cof_pkg::t_in_word              i_data,
    output logic                           o_valid,
    input  logic                           i_stall,
    output cof_pkg::t_out_word             o_data,
    input  logic                           i_cfg_we,
    input  logic [cof_pkg::CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [15:0]                    i_cfg_data
);
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);
    localparam int XW = cof_pkg::XW;
    localparam int ZW = cof_pkg::ZW;
    localparam int SW = cof_pkg::SW;
    localparam int BW = cof_pkg::BW;

    cof_pkg::t_state r_state, n_state;

    logic [AW-1:0] r_wp;
    logic          r_full;
    logic [3:0]    r_miss;
    logic [15:0]   r_bound_cfg;
    logic          r_mode;

    logic [47:0]   mem [DEPTH];
    logic [47:0]   r_rdata;
    logic [AW-1:0] raddr;

    logic [CW-1:0] r_n, r_i, r_j, r_idx, r_cnt, r_best;
    logic [BW-1:0] r_bound, r_used;
    logic [47:0]   r_si, r_sj;
    logic [1:0]    r_k;
    logic signed [SW-1:0] r_sum [3];
    logic signed [SW-1:0] r_cs [3];
    logic signed [SW-1:0] r_sn [3];
    logic signed [XW-1:0] r_cx, r_cy;
    logic signed [ZW-1:0] r_cz;
    logic          r_neg;
    logic [4:0]    r_it;
    logic [SW-1:0] r_dq;
    logic [CW-1:0] r_rem;
    logic          r_dneg;
    logic [15:0]   r_est [3];
    logic          r_ovalid;
    cof_pkg::t_out_word r_odata;

    logic          in_acc;
    logic [CW-1:0] n_cur;
    logic          j_last, i_last, k_last, cord_last, div_last, cmp_ok, incl, xy_zero;
    logic          sigma;
    logic signed [XW-1:0] sh_x, sh_y, nx, ny, ax, ay;
    logic signed [ZW-1:0] nz, rot_a;
    logic [CW:0]   dt;
    logic          qbit;
    logic [SW-1:0] q_full;

    assign in_acc    = i_valid && (r_state == cof_pkg::S_IDLE);
    assign n_cur     = r_full ? CW'(DEPTH) : CW'(r_wp);
    assign j_last    = (r_j == r_n - CW'(1));
    assign i_last    = (r_i == r_n - CW'(1));
    assign k_last    = (r_k == 2'd2);
    assign cord_last = (r_it == 5'(cof_pkg::CORDIC_STEPS - 1));
    assign div_last  = (r_it == 5'(SW - 1));
    assign cmp_ok    = cof_pkg::agree(r_si, r_rdata, r_bound, r_mode);
    assign incl      = (r_j == r_idx) || cof_pkg::agree(r_si, r_rdata, r_used, r_mode);
    assign xy_zero   = (r_cs[r_k] == '0) && (r_sn[r_k] == '0);
    assign ax        = XW'(r_cs[r_k]);
    assign ay        = XW'(r_sn[r_k]);
    assign rot_a     = ZW'(cof_pkg::axis_of(r_sj, r_k));

    always_comb begin
        sigma = (r_state == cof_pkg::S_ROT) ? !r_cz[ZW-1] : r_cy[XW-1];
        sh_x  = r_cx >>> r_it[3:0];
        sh_y  = r_cy >>> r_it[3:0];
        if (sigma) begin
            nx = r_cx - sh_y;
            ny = r_cy + sh_x;
            nz = r_cz - cof_pkg::atan_entry(r_it[3:0]);
        end else begin
            nx = r_cx + sh_y;
            ny = r_cy - sh_x;
            nz = r_cz + cof_pkg::atan_entry(r_it[3:0]);
        end
    end

    always_comb begin
        dt     = {r_rem, r_dq[SW-1]};
        qbit   = (dt >= {1'b0, r_cnt});
        q_full = {r_dq[SW-2:0], qbit};
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            cof_pkg::S_IDLE:  if (in_acc) n_state = cof_pkg::S_DET;
            cof_pkg::S_DET: begin
                if (n_cur == '0) n_state = cof_pkg::S_DONE;
                else if (n_cur == CW'(1)) n_state = cof_pkg::S_ONE;
                else n_state = cof_pkg::S_LDI;
            end
            cof_pkg::S_ONE:   n_state = cof_pkg::S_DONE;
            cof_pkg::S_LDI:   n_state = cof_pkg::S_LDI2;
            cof_pkg::S_LDI2:  n_state = cof_pkg::S_RDJ;
            cof_pkg::S_RDJ:   n_state = cof_pkg::S_CMP;
            cof_pkg::S_CMP:   n_state = j_last ? cof_pkg::S_ENDI : cof_pkg::S_RDJ;
            cof_pkg::S_ENDI:  n_state = i_last ? cof_pkg::S_ENDP : cof_pkg::S_LDI;
            cof_pkg::S_ENDP:  n_state = (r_best <= (r_n >> 1)) ? cof_pkg::S_LDI
                                                               : cof_pkg::S_GLDI;
            cof_pkg::S_GLDI:  n_state = cof_pkg::S_GLDI2;
            cof_pkg::S_GLDI2: n_state = cof_pkg::S_GRDJ;
            cof_pkg::S_GRDJ:  n_state = cof_pkg::S_GACC;
            cof_pkg::S_GACC: begin
                if (incl && r_mode) n_state = cof_pkg::S_RINIT;
                else if (j_last) n_state = r_mode ? cof_pkg::S_AINIT : cof_pkg::S_DINIT;
                else n_state = cof_pkg::S_GRDJ;
            end
            cof_pkg::S_RINIT: n_state = cof_pkg::S_ROT;
            cof_pkg::S_ROT: begin
                if (cord_last) begin
                    if (!k_last) n_state = cof_pkg::S_RINIT;
                    else n_state = j_last ? cof_pkg::S_AINIT : cof_pkg::S_GRDJ;
                end
            end
            cof_pkg::S_AINIT: begin
                if (!xy_zero) n_state = cof_pkg::S_ATAN;
                else n_state = k_last ? cof_pkg::S_DONE : cof_pkg::S_AINIT;
            end
            cof_pkg::S_ATAN: begin
                if (cord_last) n_state = k_last ? cof_pkg::S_DONE : cof_pkg::S_AINIT;
            end
            cof_pkg::S_DINIT: n_state = cof_pkg::S_DIV;
            cof_pkg::S_DIV: begin
                if (div_last) n_state = k_last ? cof_pkg::S_DONE : cof_pkg::S_DINIT;
            end
            cof_pkg::S_DONE: begin
                if (!r_ovalid || !i_stall) n_state = cof_pkg::S_IDLE;
            end
            default: n_state = cof_pkg::S_IDLE;
        endcase
    end

    always_comb begin
        o_stall = (r_state != cof_pkg::S_IDLE);
        unique case (r_state)
            cof_pkg::S_DET:  raddr = '0;
            cof_pkg::S_LDI:  raddr = r_i[AW-1:0];
            cof_pkg::S_GLDI: raddr = r_idx[AW-1:0];
            default:         raddr = r_j[AW-1:0];
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (in_acc && (i_data.func == cof_pkg::FUNC_ADD)) begin
            mem[r_wp] <= {i_data.sample_x, i_data.sample_y, i_data.sample_z};
        end
        r_rdata <= mem[raddr];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= cof_pkg::S_IDLE;
            r_wp        <= '0;
            r_full      <= 1'b0;
            r_miss      <= '0;
            r_bound_cfg <= cof_pkg::BOUND_RESET;
            r_mode      <= 1'b0;
            r_ovalid    <= 1'b0;
        end else begin
            r_state <= n_state;
            if (i_cfg_we) begin
                unique case (i_cfg_idx)
                    cof_pkg::CFG_BOUND: r_bound_cfg <= i_cfg_data;
                    cof_pkg::CFG_MODE:  r_mode      <= i_cfg_data[0];
                    default: ;
                endcase
            end
            if (in_acc) begin
                if (i_data.func == cof_pkg::FUNC_ADD) begin
                    r_miss <= '0;
                    if (r_wp == AW'(DEPTH - 1)) begin
                        r_full <= 1'b1;
                        r_wp   <= '0;
                    end else begin
                        r_wp <= r_wp + AW'(1);
                    end
                end else if (r_miss >= cof_pkg::MISS_LIMIT) begin
                    r_full <= 1'b0;
                    r_wp   <= '0;
                end else begin
                    r_miss <= r_miss + 4'd1;
                end
            end
            if ((r_state == cof_pkg::S_DONE) && (!r_ovalid || !i_stall)) begin
                r_ovalid <= 1'b1;
            end else if (!i_stall) begin
                r_ovalid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        case (r_state)
            cof_pkg::S_DET: begin
                r_n     <= n_cur;
                r_bound <= {1'b0, r_bound_cfg};
                r_used  <= {1'b0, r_bound_cfg};
                r_best  <= CW'(1);
                r_idx   <= '0;
                r_i     <= '0;
                for (int k = 0; k < 3; k++) r_est[k] <= '0;
            end
            cof_pkg::S_ONE: begin
                for (int k = 0; k < 3; k++) r_est[k] <= cof_pkg::axis_of(r_rdata, 2'(k));
            end
            cof_pkg::S_LDI2: begin
                r_si  <= r_rdata;
                r_j   <= '0;
                r_cnt <= CW'(1);
            end
            cof_pkg::S_CMP: begin
                if ((r_j != r_i) && cmp_ok) r_cnt <= r_cnt + CW'(1);
                r_j <= r_j + CW'(1);
            end
            cof_pkg::S_ENDI: begin
                if (r_cnt > r_best) begin
                    r_best <= r_cnt;
                    r_idx  <= r_i;
                end
                r_i <= r_i + CW'(1);
            end
            cof_pkg::S_ENDP: begin
                r_i    <= '0;
                r_used <= r_bound;
                if (r_bound == '0) r_bound <= BW'(1);
                else if (r_bound[BW-1]) r_bound <= cof_pkg::BOUND_MAX;
                else r_bound <= {r_bound[BW-2:0], 1'b0};
            end
            cof_pkg::S_GLDI2: begin
                r_si  <= r_rdata;
                r_j   <= '0;
                r_cnt <= '0;
                for (int k = 0; k < 3; k++) begin
                    r_sum[k] <= '0;
                    r_cs[k]  <= '0;
                    r_sn[k]  <= '0;
                end
            end
            cof_pkg::S_GACC: begin
                r_sj <= r_rdata;
                r_k  <= '0;
                if (incl) begin
                    r_cnt <= r_cnt + CW'(1);
                    for (int k = 0; k < 3; k++) begin
                        r_sum[k] <= r_sum[k] + SW'(cof_pkg::axis_of(r_rdata, 2'(k)));
                    end
                end
                if (!(incl && r_mode)) r_j <= r_j + CW'(1);
            end
            cof_pkg::S_RINIT: begin
                r_cx <= cof_pkg::CORDIC_GAIN;
                r_cy <= '0;
                r_it <= '0;
                if (rot_a > cof_pkg::QTR_TURN) begin
                    r_cz  <= rot_a - cof_pkg::HALF_TURN;
                    r_neg <= 1'b1;
                end else if (rot_a < -cof_pkg::QTR_TURN) begin
                    r_cz  <= rot_a + cof_pkg::HALF_TURN;
                    r_neg <= 1'b1;
                end else begin
                    r_cz  <= rot_a;
                    r_neg <= 1'b0;
                end
            end
            cof_pkg::S_ROT: begin
                r_cx <= nx;
                r_cy <= ny;
                r_cz <= nz;
                r_it <= r_it + 5'd1;
                if (cord_last) begin
                    r_cs[r_k] <= r_cs[r_k] + (r_neg ? SW'(-nx) : SW'(nx));
                    r_sn[r_k] <= r_sn[r_k] + (r_neg ? SW'(-ny) : SW'(ny));
                    if (k_last) begin
                        r_k <= '0;
                        r_j <= r_j + CW'(1);
                    end else begin
                        r_k <= r_k + 2'd1;
                    end
                end
            end
            cof_pkg::S_AINIT: begin
                r_it <= '0;
                if (xy_zero) begin
                    r_est[r_k] <= '0;
                    r_k        <= r_k + 2'd1;
                end else if (ax[XW-1]) begin
                    r_cx <= -ax;
                    r_cy <= -ay;
                    r_cz <= cof_pkg::HALF_TURN;
                end else begin
                    r_cx <= ax;
                    r_cy <= ay;
                    r_cz <= '0;
                end
            end
            cof_pkg::S_ATAN: begin
                r_cx <= nx;
                r_cy <= ny;
                r_cz <= nz;
                r_it <= r_it + 5'd1;
                if (cord_last) begin
                    r_est[r_k] <= nz[15:0];
                    r_k        <= r_k + 2'd1;
                end
            end
            cof_pkg::S_DINIT: begin
                r_dneg <= r_sum[r_k][SW-1];
                r_dq   <= r_sum[r_k][SW-1] ? SW'(-r_sum[r_k]) : SW'(r_sum[r_k]);
                r_rem  <= '0;
                r_it   <= '0;
            end
            cof_pkg::S_DIV: begin
                r_dq  <= q_full;
                r_rem <= qbit ? CW'(dt - {1'b0, r_cnt}) : CW'(dt);
                r_it  <= r_it + 5'd1;
                if (div_last) begin
                    r_est[r_k] <= r_dneg ? (16'd0 - q_full[15:0]) : q_full[15:0];
                    r_k        <= r_k + 2'd1;
                end
            end
            cof_pkg::S_DONE: begin
                if (!r_ovalid || !i_stall) begin
                    r_odata.estimate_x   <= r_est[0];
                    r_odata.estimate_y   <= r_est[1];
                    r_odata.estimate_z   <= r_est[2];
                    r_odata.window_full  <= r_full;
                    r_odata.sample_count <= 7'(n_cur);
                end
            end
            default: ;
        endcase
    end

    assign o_valid = r_ovalid;
    assign o_data  = r_odata;

    `COF_ASSERT_NEXT(a_acc_det, in_acc, r_state == cof_pkg::S_DET, "accepted word did not start")
    `COF_ASSERT_NOW(a_wp_range, 1'b1, r_wp <= AW'(DEPTH - 1), "write pointer out of range")
    `COF_ASSERT_NOW(a_miss_cap, 1'b1, r_miss <= cof_pkg::MISS_LIMIT, "miss count past limit")
    `COF_ASSERT_NOW(a_cmp_idx, r_state == cof_pkg::S_CMP, r_j < r_n, "compare index past fill")

endmodule

// ===== bench/consensus_outlier_filter_vec3_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Consensus outlier filter testbench
// Drives sample and tick words through the valid/stall channels under random
// bursts and output stalls, predicts each consensus estimate with a bit-exact
// model of the window, bound search, mean and CORDIC circular mean, and
// compares every result word in order. Register settings change between phases.
// ----------------------------------------------------------------------------
module consensus_outlier_filter_vec3_tb;

    localparam int WIN_DEPTH  = cof_pkg::DEPTH_DEF;
    localparam int IDLE_LIMIT = 400000;
    localparam logic [cof_pkg::CFG_IDX_W-1:0] CFG_SPARE = 2'd3;

    class consensus_board;
        int st[WIN_DEPTH][3];
        int wp;
        bit full;
        int miss;
        int bound_reg;
        bit amode;
        cof_pkg::t_out_word est_q[$];
        int mismatches;
        int results;

        function new();
            wp = 0;
            full = 0;
            miss = 0;
            bound_reg = 26;
            amode = 0;
            mismatches = 0;
            results = 0;
            foreach (st[i, k]) st[i][k] = 0;
        endfunction

        function void set_reg(logic [cof_pkg::CFG_IDX_W-1:0] idx, logic [15:0] d);
            if (idx == cof_pkg::CFG_BOUND) bound_reg = d;
            else if (idx == cof_pkg::CFG_MODE) amode = d[0];
        endfunction

        function int axis_gap(int a, int b);
            int d;
            int w;
            d = a - b;
            if (!amode) return d < 0 ? -d : d;
            w = d & 65535;
            return w >= 32768 ? 65536 - w : w;
        endfunction

        function bit close_to(int i, int j, int bnd);
            for (int k = 0; k < 3; k++)
                if (axis_gap(st[i][k], st[j][k]) >= bnd) return 0;
            return 1;
        endfunction

        function int atan_step(int i);
            int tab[14] = '{8192, 4836, 2555, 1297, 651, 326, 163, 81, 41, 20, 10, 5, 3, 1};
            return tab[i];
        endfunction

        function void rotate(int a, output int c, output int s);
            int x;
            int y;
            int z;
            int dx;
            int dy;
            bit neg;
            x = 9949;
            y = 0;
            z = a;
            neg = 0;
            if (z > 16384) begin
                z -= 32768;
                neg = 1;
            end else if (z < -16384) begin
                z += 32768;
                neg = 1;
            end
            for (int i = 0; i < 14; i++) begin
                dx = y >>> i;
                dy = x >>> i;
                if (z >= 0) begin
                    x -= dx; y += dy; z -= atan_step(i);
                end else begin
                    x += dx; y -= dy; z += atan_step(i);
                end
            end
            c = neg ? -x : x;
            s = neg ? -y : y;
        endfunction

        function logic signed [15:0] heading(int y, int x);
            int z;
            int dx;
            int dy;
            logic [31:0] zb;
            z = 0;
            if (x == 0 && y == 0) return 16'sd0;
            if (x < 0) begin
                x = -x; y = -y; z = 32768;
            end
            for (int i = 0; i < 14; i++) begin
                dx = y >>> i;
                dy = x >>> i;
                if (y >= 0) begin
                    x += dx; y -= dy; z += atan_step(i);
                end else begin
                    x -= dx; y += dy; z -= atan_step(i);
                end
            end
            zb = z;
            return zb[15:0];
        endfunction

        function void note(cof_pkg::t_in_word w);
            cof_pkg::t_out_word r;
            int n, bnd, used, best, idx, cnt, c, s;
            int sum[3];
            int cs[3];
            int sn[3];
            if (w.func == cof_pkg::FUNC_ADD) begin
                st[wp][0] = w.sample_x;
                st[wp][1] = w.sample_y;
                st[wp][2] = w.sample_z;
                miss = 0;
                wp++;
                if (wp >= WIN_DEPTH) begin
                    full = 1;
                    wp = 0;
                end
            end else if (miss >= 8) begin
                full = 0;
                wp = 0;
            end else begin
                miss++;
            end
            r = '0;
            n = full ? WIN_DEPTH : wp;
            if (n == 1) begin
                r.estimate_x = st[0][0];
                r.estimate_y = st[0][1];
                r.estimate_z = st[0][2];
            end else if (n > 1) begin
                bnd = bound_reg;
                used = bnd;
                best = 1;
                idx = 0;
                while (best <= n / 2) begin
                    used = bnd;
                    for (int i = 0; i < n; i++) begin
                        cnt = 1;
                        for (int j = 0; j < n; j++)
                            if (j != i && close_to(i, j, bnd)) cnt++;
                        if (cnt > best) begin
                            best = cnt;
                            idx = i;
                        end
                    end
                    if (bnd == 0) bnd = 1;
                    else bnd = (bnd * 2 > 131071) ? 131071 : bnd * 2;
                end
                cnt = 0;
                for (int k = 0; k < 3; k++) begin
                    sum[k] = 0; cs[k] = 0; sn[k] = 0;
                end
                for (int j = 0; j < n; j++) begin
                    if (j == idx || close_to(idx, j, used)) begin
                        cnt++;
                        for (int k = 0; k < 3; k++) begin
                            sum[k] += st[j][k];
                            rotate(st[j][k], c, s);
                            cs[k] += c;
                            sn[k] += s;
                        end
                    end
                end
                if (amode) begin
                    r.estimate_x = heading(sn[0], cs[0]);
                    r.estimate_y = heading(sn[1], cs[1]);
                    r.estimate_z = heading(sn[2], cs[2]);
                end else begin
                    r.estimate_x = 16'(sum[0] / cnt);
                    r.estimate_y = 16'(sum[1] / cnt);
                    r.estimate_z = 16'(sum[2] / cnt);
                end
            end
            r.window_full = full;
            r.sample_count = full ? 7'(WIN_DEPTH) : 7'(wp);
            est_q.push_back(r);
        endfunction

        function void check(cof_pkg::t_out_word got);
            cof_pkg::t_out_word exp_w;
            results++;
            if (est_q.size() == 0) begin
                mismatches++;
                if (mismatches <= 10) $display("Result word with no estimate pending: %h", got);
                return;
            end
            exp_w = est_q.pop_front();
            if (got !== exp_w) begin
                mismatches++;
                if (mismatches <= 10) begin
                    $display("Mismatch at result %0d: expected x=%0d y=%0d z=%0d full=%0b cnt=%0d",
                             results, exp_w.estimate_x, exp_w.estimate_y, exp_w.estimate_z,
                             exp_w.window_full, exp_w.sample_count);
                    $display("    got x=%0d y=%0d z=%0d full=%0b cnt=%0d",
                             got.estimate_x, got.estimate_y, got.estimate_z,
                             got.window_full, got.sample_count);
                end
            end
        endfunction
    endclass

    logic i_clk;
    logic i_rst_n;
    logic i_valid;
    logic o_stall;
    cof_pkg::t_in_word i_data;
    logic o_valid;
    logic i_stall;
    cof_pkg::t_out_word o_data;
    logic i_cfg_we;
    logic [cof_pkg::CFG_IDX_W-1:0] i_cfg_idx;
    logic [15:0] i_cfg_data;

    consensus_board board;
    int idle_cycles;
    int words_sent;
    int ticks_sent;
    int angle_words;
    logic [15:0] center[3];

    consensus_outlier_filter_vec3 i_dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_valid    (i_valid),
        .o_stall    (o_stall),
        .i_data     (i_data),
        .o_valid    (o_valid),
        .i_stall    (i_stall),
        .o_data     (o_data),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_valid && !i_stall) board.check(o_data);
        if ((i_valid && !o_stall) || (o_valid && !i_stall) || !i_rst_n) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= IDLE_LIMIT) begin
                $display("end of test: mismatches");
                $finish;
            end
        end
    end

    initial begin
        int mode;
        int len;
        i_stall = 1'b0;
        forever begin
            mode = $urandom_range(0, 2);
            len = $urandom_range(20, 300);
            repeat (len) begin
                @(negedge i_clk);
                case (mode)
                    0: i_stall <= 1'b0;
                    1: i_stall <= ($urandom_range(0, 9) < 3);
                    default: i_stall <= ($urandom_range(0, 9) < 8);
                endcase
            end
        end
    end

    task automatic send_word(cof_pkg::t_in_word w);
        @(negedge i_clk);
        i_valid <= 1'b1;
        i_data <= w;
        do @(posedge i_clk); while (o_stall);
        board.note(w);
        words_sent++;
        if (w.func == cof_pkg::FUNC_TICK) ticks_sent++;
        if (board.amode) angle_words++;
    endtask

    task automatic pause_sender();
        int gap;
        if ($urandom_range(0, 3) == 0) begin
            gap = $urandom_range(1, 40);
            @(negedge i_clk);
            i_valid <= 1'b0;
            repeat (gap - 1) @(negedge i_clk);
        end
    endtask

    task automatic drain();
        @(negedge i_clk);
        i_valid <= 1'b0;
        while (board.est_q.size() != 0) @(posedge i_clk);
        repeat (20) @(posedge i_clk);
    endtask

    task automatic write_reg(logic [cof_pkg::CFG_IDX_W-1:0] idx, logic [15:0] d);
        @(negedge i_clk);
        i_cfg_we <= 1'b1;
        i_cfg_idx <= idx;
        i_cfg_data <= d;
        @(posedge i_clk);
        board.set_reg(idx, d);
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
    endtask

    function automatic cof_pkg::t_in_word make_word(logic f, logic [15:0] x, logic [15:0] y,
                                                    logic [15:0] z);
        cof_pkg::t_in_word w;
        w.func = f;
        w.sample_x = x;
        w.sample_y = y;
        w.sample_z = z;
        return w;
    endfunction

    function automatic logic [15:0] near(logic [15:0] c, int spread);
        return c + 16'($urandom_range(0, 2 * spread) - spread);
    endfunction

    task automatic random_phase(int count);
        int spread;
        int k;
        int run;
        for (int a = 0; a < 3; a++) center[a] = $urandom;
        spread = $urandom_range(2, 60);
        k = 0;
        while (k < count) begin
            pause_sender();
            case ($urandom_range(0, 19))
                0: begin
                    run = $urandom_range(1, 12);
                    repeat (run) send_word(make_word(cof_pkg::FUNC_TICK, $urandom, $urandom,
                                                     $urandom));
                    k += run;
                end
                1, 2, 3: begin
                    send_word(make_word(cof_pkg::FUNC_ADD, $urandom, $urandom, $urandom));
                    k++;
                end
                4: begin
                    for (int a = 0; a < 3; a++) center[a] = $urandom;
                    spread = $urandom_range(0, 400);
                end
                default: begin
                    send_word(make_word(cof_pkg::FUNC_ADD, near(center[0], spread),
                                        near(center[1], spread), near(center[2], spread)));
                    k++;
                end
            endcase
        end
        drain();
    endtask

    initial begin
        board = new();
        idle_cycles = 0;
        words_sent = 0;
        ticks_sent = 0;
        angle_words = 0;
        i_rst_n = 1'b0;
        i_valid = 1'b0;
        i_data = '0;
        i_cfg_we = 1'b0;
        i_cfg_idx = cof_pkg::CFG_BOUND;
        i_cfg_data = 16'd0;
        repeat (11) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Empty window, single sample, extremes, wrap-around and window clearing.
        send_word(make_word(cof_pkg::FUNC_TICK, 16'h0000, 16'h0000, 16'h0000));
        send_word(make_word(cof_pkg::FUNC_ADD, 16'h7FFF, 16'h8000, 16'hFFFF));
        send_word(make_word(cof_pkg::FUNC_ADD, 16'h8000, 16'h7FFF, 16'h0000));
        send_word(make_word(cof_pkg::FUNC_ADD, 16'h7FF0, 16'h8010, 16'hFFF8));
        send_word(make_word(cof_pkg::FUNC_ADD, 16'h0000, 16'h0000, 16'h0001));
        repeat (9) send_word(make_word(cof_pkg::FUNC_TICK, 16'hFFFF, 16'hFFFF, 16'hFFFF));
        repeat (12) send_word(make_word(cof_pkg::FUNC_ADD, 16'($urandom_range(0, 40) - 20),
                                        16'h5555, 16'hAAAA));
        drain();
        write_reg(cof_pkg::CFG_MODE, 16'hFFFF);
        send_word(make_word(cof_pkg::FUNC_ADD, 16'h7FFF, 16'h8000, 16'h4000));
        send_word(make_word(cof_pkg::FUNC_ADD, 16'h8001, 16'h7FFE, 16'hC000));
        drain();
        write_reg(CFG_SPARE, 16'hFFFF);
        write_reg(cof_pkg::CFG_MODE, 16'h0000);

        random_phase(80);
        write_reg(cof_pkg::CFG_BOUND, 16'd0);
        random_phase(70);
        write_reg(cof_pkg::CFG_BOUND, 16'hFFFF);
        random_phase(70);
        write_reg(cof_pkg::CFG_MODE, 16'd1);
        write_reg(cof_pkg::CFG_BOUND, 16'd40);
        random_phase(90);
        write_reg(cof_pkg::CFG_BOUND, 16'd0);
        random_phase(70);
        write_reg(cof_pkg::CFG_BOUND, 16'hFFFF);
        random_phase(70);
        write_reg(cof_pkg::CFG_MODE, 16'd0);
        write_reg(cof_pkg::CFG_BOUND, 16'd300);
        random_phase(80);

        $display("Covered %0d words (%0d ticks, %0d in angle mode), %0d results checked.",
                 words_sent, ticks_sent, angle_words, board.results);
        $display("Register settings ran from zero to full-scale bound in both modes.");
        if (board.mismatches == 0 && board.est_q.size() == 0) begin
            $display("end of test: clean");
        end else begin
            $display("end of test: mismatches");
        end
        $finish;
    end
endmodule
